>>> src/assert_macros.svh
// Assertion helper macros for the lexer RTL.
// Users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stl_pkg.sv
// Shared types, token codes and keyword tables for the script token lexer.
// No dependencies.
`default_nettype none

package stl_pkg;

  localparam int DEF_MAX_STRING_BYTES = 4095;
  localparam int DEF_POSITION_BITS    = 16;

  localparam int KW_COUNT   = 13;
  localparam int KW_MAXLEN  = 7;
  localparam int MAX_RES    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [62:0] INT_MAX63 = {63{1'b1}};
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  // token kinds
  localparam logic [5:0] K_IDENT   = 6'd0;
  localparam logic [5:0] K_STRING  = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_FLOAT   = 6'd3;
  localparam logic [5:0] K_KW0     = 6'd4;
  localparam logic [5:0] K_LPAREN  = 6'd17;
  localparam logic [5:0] K_RPAREN  = 6'd18;
  localparam logic [5:0] K_LBRACE  = 6'd19;
  localparam logic [5:0] K_RBRACE  = 6'd20;
  localparam logic [5:0] K_LBRACK  = 6'd21;
  localparam logic [5:0] K_RBRACK  = 6'd22;
  localparam logic [5:0] K_COMMA   = 6'd23;
  localparam logic [5:0] K_COLON   = 6'd24;
  localparam logic [5:0] K_DOT     = 6'd25;
  localparam logic [5:0] K_PLUS    = 6'd26;
  localparam logic [5:0] K_MINUS   = 6'd27;
  localparam logic [5:0] K_STAR    = 6'd28;
  localparam logic [5:0] K_SLASH   = 6'd29;
  localparam logic [5:0] K_PCT     = 6'd30;
  localparam logic [5:0] K_ASSIGN  = 6'd31;
  localparam logic [5:0] K_EQEQ    = 6'd32;
  localparam logic [5:0] K_NEQ     = 6'd33;
  localparam logic [5:0] K_LT      = 6'd34;
  localparam logic [5:0] K_GT      = 6'd35;
  localparam logic [5:0] K_LE      = 6'd36;
  localparam logic [5:0] K_GE      = 6'd37;
  localparam logic [5:0] K_NEWLINE = 6'd38;
  localparam logic [5:0] K_EOF     = 6'd39;
  localparam logic [5:0] K_ERROR   = 6'd40;
  localparam logic [5:0] K_SBYTE   = 6'd41;

  // error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNTERM  = 2'd1;
  localparam logic [1:0] E_BANG    = 2'd2;
  localparam logic [1:0] E_ILLEGAL = 2'd3;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UND   = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LT_T  = 8'h74;

  // print if elif else while def return and or not True False None
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00},
    '{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00},
    '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "r", "u", "e", 8'h00, 8'h00, 8'h00},
    '{"F", "a", "l", "s", "e", 8'h00, 8'h00},
    '{"N", "o", "n", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4
  };

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_NEWLINES, M_IDENT, M_INT, M_INT_DOT, M_FLOAT,
    M_STRING, M_STRING_ESC, M_EQ, M_BANG, M_LT, M_GT
  } stl_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       is_end;
  } stl_in_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  error_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic [62:0] integer_value;
    logic [7:0]  text_byte;
    logic        last;
  } stl_out_t;

  // all results caused by one item
  typedef struct packed {
    stl_out_t [MAX_RES-1:0] res;
    logic [1:0]             count;
  } stl_bundle_t;

  typedef struct packed {
    logic [QCW-1:0] q_count;
    logic [1:0]     sub;
    logic [1:0]     head_count;
  } stl_back_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UND);
  endfunction

  // {hit, kind} for single-character operators
  function automatic logic [6:0] op_lookup(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "(":     r = {1'b1, K_LPAREN};
      ")":     r = {1'b1, K_RPAREN};
      "{":     r = {1'b1, K_LBRACE};
      "}":     r = {1'b1, K_RBRACE};
      "[":     r = {1'b1, K_LBRACK};
      "]":     r = {1'b1, K_RBRACK};
      ",":     r = {1'b1, K_COMMA};
      ":":     r = {1'b1, K_COLON};
      ".":     r = {1'b1, K_DOT};
      "+":     r = {1'b1, K_PLUS};
      "-":     r = {1'b1, K_MINUS};
      "*":     r = {1'b1, K_STAR};
      "/":     r = {1'b1, K_SLASH};
      "%":     r = {1'b1, K_PCT};
      default: r = {1'b0, K_IDENT};
    endcase
    return r;
  endfunction

  // drop keywords that no longer match at this character position
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                    input logic [7:0] c,
                                                    input logic [15:0] idx);
    logic [KW_COUNT-1:0] r;
    r = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!((idx < 16'(KW_LEN[k])) && (KW_TEXT[k][idx[2:0]] == c))) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [KW_COUNT-1:0] cand,
                                            input logic [15:0] len);
    logic [5:0] r;
    r = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand[k] && (16'(KW_LEN[k]) == len)) r = K_KW0 + 6'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/stl_front.sv
// Front end: per-byte scanner state machine, classifies a byte and builds
// the bundle of results it causes. Depends on stl_pkg.
`default_nettype none

module stl_front import stl_pkg::*; #(
  parameter int MAX_STRING_BYTES = DEF_MAX_STRING_BYTES,
  parameter int POSITION_BITS    = DEF_POSITION_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire stl_in_t item,
  output stl_bundle_t bundle,
  output stl_mode_t  mode
);

  localparam int PB = POSITION_BITS;
  localparam int SB = $clog2(MAX_STRING_BYTES + 1);
  localparam int DW = ((PB > 16) ? PB : 16) + 1;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
  localparam logic [PB-1:0] POS_ONE = PB'(1);

  stl_mode_t mode_r, mode_nxt;
  logic [PB-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [PB-1:0] tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [PB-1:0] eline_r, eline_nxt, ecol_r, ecol_nxt;
  logic [15:0]   tlen_r, tlen_nxt;
  logic [62:0]   acc_r, acc_nxt;
  logic [KW_COUNT-1:0] kw_r, kw_nxt;
  logic [SB-1:0] sbc_r, sbc_nxt;

  function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] v);
    return (v < POS_MAX) ? v + POS_ONE : POS_MAX;
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    return (v < LEN_MAX) ? v + 16'd1 : LEN_MAX;
  endfunction

  function automatic logic [15:0] to16(input logic [PB-1:0] v);
    logic [PB+15:0] t;
    t = {16'd0, v};
    return t[15:0];
  endfunction

  function automatic stl_out_t mk(input logic [5:0] kind, input logic [1:0] err,
                                  input logic [PB-1:0] ln, input logic [PB-1:0] cl,
                                  input logic [15:0] len, input logic [62:0] val,
                                  input logic [7:0] tb);
    stl_out_t r;
    r.kind          = kind;
    r.error_code    = err;
    r.start_line    = to16(ln);
    r.start_column  = to16(cl);
    r.token_length  = len;
    r.integer_value = val;
    r.text_byte     = tb;
    r.last          = 1'b0;
    return r;
  endfunction

  logic [7:0]    c;
  logic          again;
  logic [1:0]    n;
  logic [PB-1:0] adv_line, adv_col;
  logic [DW-1:0] dcw;
  logic [PB-1:0] dot_col;
  logic [66:0]   prod;
  logic [62:0]   acc_step;
  logic [6:0]    op;
  logic [7:0]    esc_val;

  always_comb begin
    c = item.source_byte;
    adv_line = (c == CH_NL) ? pos_inc(line_r) : line_r;
    adv_col  = (c == CH_NL) ? POS_ONE : pos_inc(col_r);
    dcw = DW'(tcol_r) + DW'(tlen_r);
    dot_col = (dcw >= DW'(POS_MAX)) ? POS_MAX : dcw[PB-1:0];
    prod = (67'(acc_r) << 3) + (67'(acc_r) << 1) + 67'(c - CH_0);
    acc_step = (prod > 67'(INT_MAX63)) ? INT_MAX63 : prod[62:0];
    op = op_lookup(c);
    esc_val = (c == CH_LN) ? CH_NL : (c == CH_LT_T) ? CH_TAB : c;
  end

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    eline_nxt = eline_r;
    ecol_nxt  = ecol_r;
    tlen_nxt  = tlen_r;
    acc_nxt   = acc_r;
    kw_nxt    = kw_r;
    sbc_nxt   = sbc_r;
    bundle    = '0;
    n         = 2'd0;
    again     = 1'b0;
    if (accept) begin
      if (item.is_end) begin
        case (mode_r)
          M_NEWLINES: begin
            bundle.res[n] = mk(K_NEWLINE, E_NONE, tline_r, tcol_r, tlen_r, '0, '0);
            n = n + 2'd1;
          end
          M_IDENT: begin
            bundle.res[n] = mk(ident_kind(kw_r, tlen_r), E_NONE, tline_r, tcol_r,
                               tlen_r, '0, '0);
            n = n + 2'd1;
          end
          M_INT: begin
            bundle.res[n] = mk(K_INT, E_NONE, tline_r, tcol_r, tlen_r, acc_r, '0);
            n = n + 2'd1;
          end
          M_INT_DOT: begin
            bundle.res[n] = mk(K_INT, E_NONE, tline_r, tcol_r, tlen_r, acc_r, '0);
            n = n + 2'd1;
            bundle.res[n] = mk(K_DOT, E_NONE, tline_r, dot_col, 16'd1, '0, '0);
            n = n + 2'd1;
          end
          M_FLOAT: begin
            bundle.res[n] = mk(K_FLOAT, E_NONE, tline_r, tcol_r, tlen_r, '0, '0);
            n = n + 2'd1;
          end
          M_STRING, M_STRING_ESC: begin
            bundle.res[n] = mk(K_ERROR, E_UNTERM, tline_r, tcol_r, tlen_r, '0, '0);
            n = n + 2'd1;
          end
          M_EQ: begin
            bundle.res[n] = mk(K_ASSIGN, E_NONE, tline_r, tcol_r, 16'd1, '0, '0);
            n = n + 2'd1;
          end
          M_BANG: begin
            bundle.res[n] = mk(K_ERROR, E_BANG, tline_r, tcol_r, 16'd1, '0, '0);
            n = n + 2'd1;
          end
          M_LT: begin
            bundle.res[n] = mk(K_LT, E_NONE, tline_r, tcol_r, 16'd1, '0, '0);
            n = n + 2'd1;
          end
          M_GT: begin
            bundle.res[n] = mk(K_GT, E_NONE, tline_r, tcol_r, 16'd1, '0, '0);
            n = n + 2'd1;
          end
          default: ;
        endcase
        bundle.res[n] = mk(K_EOF, E_NONE, line_r, col_r, 16'd0, '0, '0);
        n = n + 2'd1;
        mode_nxt  = M_IDLE;
        line_nxt  = POS_ONE;
        col_nxt   = POS_ONE;
        tline_nxt = POS_ONE;
        tcol_nxt  = POS_ONE;
        eline_nxt = POS_ONE;
        ecol_nxt  = POS_ONE;
        tlen_nxt  = 16'd0;
        acc_nxt   = '0;
        kw_nxt    = '1;
        sbc_nxt   = '0;
      end else begin
        // first pass: finish or extend the pending token
        case (mode_r)
          M_COMMENT: begin
            if (c == CH_NL) again = 1'b1;
            else begin
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end
          end
          M_NEWLINES: begin
            if (c == CH_NL) begin
              tlen_nxt = len_inc(tlen_r);
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk(K_NEWLINE, E_NONE, tline_r, tcol_r, tlen_r, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              kw_nxt   = kw_filter(kw_r, c, tlen_r);
              tlen_nxt = len_inc(tlen_r);
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk(ident_kind(kw_r, tlen_r), E_NONE, tline_r, tcol_r,
                                 tlen_r, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(c)) begin
              acc_nxt  = acc_step;
              tlen_nxt = len_inc(tlen_r);
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else if (c == CH_DOT) begin
              mode_nxt = M_INT_DOT;
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk(K_INT, E_NONE, tline_r, tcol_r, tlen_r, acc_r, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          M_INT_DOT: begin
            if (is_digit(c)) begin
              tlen_nxt = len_inc(len_inc(tlen_r));
              mode_nxt = M_FLOAT;
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk(K_INT, E_NONE, tline_r, tcol_r, tlen_r, acc_r, '0);
              n = n + 2'd1;
              bundle.res[n] = mk(K_DOT, E_NONE, tline_r, dot_col, 16'd1, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(c)) begin
              tlen_nxt = len_inc(tlen_r);
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk(K_FLOAT, E_NONE, tline_r, tcol_r, tlen_r, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          M_STRING: begin
            if (c == CH_QUOTE) begin
              tlen_nxt = len_inc(tlen_r);
              bundle.res[n] = mk(K_STRING, E_NONE, tline_r, tcol_r, len_inc(tlen_r),
                                 '0, '0);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else if ((c == CH_NL) || (32'(sbc_r) >= 32'(MAX_STRING_BYTES))) begin
              bundle.res[n] = mk(K_ERROR, E_UNTERM, tline_r, tcol_r, tlen_r, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end else if (c == CH_BSL) begin
              eline_nxt = line_r;
              ecol_nxt  = col_r;
              tlen_nxt  = len_inc(tlen_r);
              mode_nxt  = M_STRING_ESC;
              line_nxt  = adv_line;
              col_nxt   = adv_col;
            end else begin
              bundle.res[n] = mk(K_SBYTE, E_NONE, line_r, col_r, 16'd1, '0, c);
              n = n + 2'd1;
              sbc_nxt  = sbc_r + SB'(1);
              tlen_nxt = len_inc(tlen_r);
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end
          end
          M_STRING_ESC: begin
            bundle.res[n] = mk(K_SBYTE, E_NONE, eline_r, ecol_r, 16'd2, '0, esc_val);
            n = n + 2'd1;
            sbc_nxt  = sbc_r + SB'(1);
            tlen_nxt = len_inc(tlen_r);
            mode_nxt = M_STRING;
            line_nxt = adv_line;
            col_nxt  = adv_col;
          end
          M_EQ, M_BANG, M_LT, M_GT: begin
            mode_nxt = M_IDLE;
            if (c == CH_EQ) begin
              bundle.res[n] = mk((mode_r == M_EQ) ? K_EQEQ : (mode_r == M_BANG) ? K_NEQ :
                                 (mode_r == M_LT) ? K_LE : K_GE,
                                 E_NONE, tline_r, tcol_r, 16'd2, '0, '0);
              n = n + 2'd1;
              line_nxt = adv_line;
              col_nxt  = adv_col;
            end else begin
              bundle.res[n] = mk((mode_r == M_EQ) ? K_ASSIGN : (mode_r == M_BANG) ? K_ERROR :
                                 (mode_r == M_LT) ? K_LT : K_GT,
                                 (mode_r == M_BANG) ? E_BANG : E_NONE,
                                 tline_r, tcol_r, 16'd1, '0, '0);
              n = n + 2'd1;
              again = 1'b1;
            end
          end
          default: again = 1'b1;
        endcase

        // second pass: byte lexed from idle
        if (again) begin
          mode_nxt = M_IDLE;
          line_nxt = adv_line;
          col_nxt  = adv_col;
          if ((c == CH_SP) || (c == CH_TAB) || (c == CH_CR)) begin
            mode_nxt = M_IDLE;
          end else if (c == CH_HASH) begin
            mode_nxt = M_COMMENT;
          end else if (op[6]) begin
            bundle.res[n] = mk(op[5:0], E_NONE, line_r, col_r, 16'd1, '0, '0);
            n = n + 2'd1;
          end else begin
            tline_nxt = line_r;
            tcol_nxt  = col_r;
            tlen_nxt  = 16'd1;
            if (c == CH_NL) mode_nxt = M_NEWLINES;
            else if (c == CH_EQ) mode_nxt = M_EQ;
            else if (c == CH_BANG) mode_nxt = M_BANG;
            else if (c == CH_LT) mode_nxt = M_LT;
            else if (c == CH_GT) mode_nxt = M_GT;
            else if (c == CH_QUOTE) begin
              sbc_nxt  = '0;
              mode_nxt = M_STRING;
            end else if (is_digit(c)) begin
              acc_nxt  = 63'(c - CH_0);
              mode_nxt = M_INT;
            end else if (is_alpha(c)) begin
              kw_nxt   = kw_filter('1, c, 16'd0);
              mode_nxt = M_IDENT;
            end else begin
              bundle.res[n] = mk(K_ERROR, E_ILLEGAL, line_r, col_r, 16'd1, '0, '0);
              n = n + 2'd1;
            end
          end
        end
      end
      if (n != 2'd0) bundle.res[n - 2'd1].last = 1'b1;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      line_r  <= POS_ONE;
      col_r   <= POS_ONE;
      tline_r <= POS_ONE;
      tcol_r  <= POS_ONE;
      eline_r <= POS_ONE;
      ecol_r  <= POS_ONE;
      tlen_r  <= 16'd0;
      acc_r   <= '0;
      kw_r    <= '1;
      sbc_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      eline_r <= eline_nxt;
      ecol_r  <= ecol_nxt;
      tlen_r  <= tlen_nxt;
      acc_r   <= acc_nxt;
      kw_r    <= kw_nxt;
      sbc_r   <= sbc_nxt;
    end
  end

  assign mode = mode_r;

endmodule

`default_nettype wire

>>> src/stl_back.sv
// Back end: bundle queue plus serializer into the output register.
// Depends on stl_pkg.
`default_nettype none

module stl_back import stl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire stl_bundle_t bundle,
  output logic             full,
  output logic             out_valid,
  input  wire logic        out_stall,
  output stl_out_t         out_data,
  output stl_back_stat_t   stat
);

  stl_bundle_t    q_mem [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     sub_r, sub_nxt;
  logic           out_valid_r, out_valid_nxt;
  stl_out_t       out_data_r;
  stl_bundle_t    head;
  logic           load, pop;

  always_comb begin
    head = q_mem[rd_ptr_r];
    full = (cnt_r == QCW'(QUEUE_DEPTH));
    load = (!out_valid_r || !out_stall) && (cnt_r != '0);
    pop  = load && (sub_r == head.count - 2'd1);
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
    sub_nxt    = pop ? 2'd0 : (load ? sub_r + 2'd1 : sub_r);
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= bundle;
    if (load) out_data_r <= head.res[sub_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      sub_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.q_count    = cnt_r;
  assign stat.sub        = sub_r;
  assign stat.head_count = head.count;

endmodule

`default_nettype wire

>>> src/script_token_lexer.sv
// Top level of the script token lexer: scanner front end, bundle queue and
// output serializer. Depends on stl_pkg, stl_front, stl_back, assert_macros.svh.
//
// Usage:
//  - in_valid/in_stall/in_item carry one source byte per item; is_end set
//    marks end of source (byte ignored), which flushes any pending token,
//    emits EOF and returns the scanner to its reset state.
//  - out_valid/out_stall/out_data carry one token per item; out_data.last
//    marks the final token caused by an input item. A byte may cause 0..3
//    tokens.
//  - Throughput: one byte per cycle while each byte yields at most one token
//    and out_stall is low; the tokens of one byte leave the output in turn.
//  - A token travels from its taken byte to out_valid through the queue
//    write and then the output register load.
//  - in_stall rises only when the 4-entry bundle queue is full, i.e. when
//    the receiver has stalled the output long enough or multi-token bytes
//    arrive faster than they drain.
//  - Reset (rst_n low, synchronous) returns the scanner to idle at line 1,
//    column 1 and empties the queue; out_valid drops.
//  - A stalled output item holds until taken.
`default_nettype none
`include "assert_macros.svh"

module script_token_lexer import stl_pkg::*; #(
  parameter int MAX_STRING_BYTES = DEF_MAX_STRING_BYTES,
  parameter int POSITION_BITS    = DEF_POSITION_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire stl_in_t in_item,
  output logic         out_valid,
  input  wire logic    out_stall,
  output stl_out_t     out_data
);

  logic           in_accept;
  stl_bundle_t    bundle;
  stl_mode_t      front_mode;
  stl_back_stat_t stat;
  logic           q_full;

  // item taken whenever the queue has a free slot
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  stl_front #(
    .MAX_STRING_BYTES(MAX_STRING_BYTES),
    .POSITION_BITS   (POSITION_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(in_accept),
    .item  (in_item),
    .bundle(bundle),
    .mode  (front_mode)
  );

  // only bundles holding tokens enter the queue
  stl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept && (bundle.count != 2'd0)),
    .bundle   (bundle),
    .full     (q_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .stat     (stat)
  );

  // end of source always leaves the scanner idle
  `ASSERT_NXT(a_end_idle, in_accept && in_item.is_end, front_mode == M_IDLE, "not idle after end")
  // queue occupancy bounded by depth
  `ASSERT_IMP(a_q_bound, 1'b1, stat.q_count <= QCW'(QUEUE_DEPTH), "queue overflow")
  // serializer index stays inside the head bundle
  `ASSERT_IMP(a_sub_range, stat.q_count != '0, stat.sub < stat.head_count, "bad sub index")

endmodule

`default_nettype wire

>>> bench/stl_checker.sv
// Token checker for the script token lexer: predicts the tokens for each
// accepted byte and compares them in order with the output channel.
// Depends on stl_pkg.
`default_nettype none

module stl_checker import stl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire stl_in_t  in_item,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire stl_out_t out_data,
  output int            errors,
  output int            pending
);

  localparam int STR_LIMIT = 4095;

  stl_out_t token_q[$];
  int err_count = 0;

  stl_mode_t   mode;
  logic [15:0] cur_line, cur_col, tok_line, tok_col, tok_len, esc_line, esc_col;
  logic [63:0] acc;
  logic [12:0] cand;
  int          str_bytes;

  string kw_names[13] = '{"print", "if", "elif", "else", "while", "def", "return",
                          "and", "or", "not", "True", "False", "None"};
  string single_ops = "(){}[],:.+-*/%";

  assign errors  = err_count;
  assign pending = token_q.size();

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UND;
  endfunction

  task automatic clear_state();
    mode = M_IDLE;
    cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1; tok_len = 0;
    acc = 0; cand = '1; str_bytes = 0; esc_line = 1; esc_col = 1;
  endtask

  task automatic push(input logic [5:0] k, input logic [1:0] e, input logic [15:0] ln,
                      input logic [15:0] col, input logic [15:0] len,
                      input logic [62:0] val, input logic [7:0] tb);
    stl_out_t r;
    r = '{kind: k, error_code: e, start_line: ln, start_column: col, token_length: len,
          integer_value: val, text_byte: tb, last: 1'b0};
    token_q.push_back(r);
  endtask

  task automatic push_tok(input logic [5:0] k, input logic [1:0] e,
                          input logic [15:0] len, input logic [62:0] val);
    push(k, e, tok_line, tok_col, len, val, 8'h00);
  endtask

  task automatic step_pos(input logic [7:0] c);
    if (c == CH_NL) begin
      cur_line = sat_inc(cur_line);
      cur_col = 1;
    end else begin
      cur_col = sat_inc(cur_col);
    end
  endtask

  task automatic narrow_keywords(input logic [7:0] c, input logic [15:0] idx);
    for (int k = 0; k < 13; k++)
      if (cand[k] && !(idx < kw_names[k].len() && kw_names[k][idx] == c)) cand[k] = 1'b0;
  endtask

  task automatic close_word();
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 13; i++)
      if (cand[i] && kw_names[i].len() == tok_len) k = K_KW0 + 6'(i);
    push_tok(k, E_NONE, tok_len, 0);
  endtask

  // "12." with no digit after the dot: int token, then the dot on its own
  task automatic close_int_dot();
    logic [16:0] dc;
    dc = tok_col + tok_len;
    push_tok(K_INT, E_NONE, tok_len, acc[62:0]);
    push(K_DOT, E_NONE, tok_line, (dc > 17'hFFFF) ? 16'hFFFF : dc[15:0], 1, 0, 8'h00);
  endtask

  task automatic scan_idle(input logic [7:0] c);
    if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
      step_pos(c);
      return;
    end
    if (c == CH_HASH) begin
      mode = M_COMMENT;
      step_pos(c);
      return;
    end
    for (int k = 0; k < 14; k++) begin
      if (single_ops[k] == c) begin
        push(K_LPAREN + 6'(k), E_NONE, cur_line, cur_col, 1, 0, 8'h00);
        step_pos(c);
        return;
      end
    end
    tok_line = cur_line;
    tok_col = cur_col;
    tok_len = 1;
    if (c == CH_NL) mode = M_NEWLINES;
    else if (c == CH_EQ) mode = M_EQ;
    else if (c == CH_BANG) mode = M_BANG;
    else if (c == CH_LT) mode = M_LT;
    else if (c == CH_GT) mode = M_GT;
    else if (c == CH_QUOTE) begin
      str_bytes = 0;
      mode = M_STRING;
    end else if (digit(c)) begin
      acc = 64'(c - CH_0);
      mode = M_INT;
    end else if (letter(c)) begin
      cand = '1;
      narrow_keywords(c, 0);
      mode = M_IDENT;
    end else begin
      push_tok(K_ERROR, E_ILLEGAL, 1, 0);
    end
    step_pos(c);
  endtask

  // two-character operator candidates; rescan is 1 when the byte is lexed anew
  task automatic pair_op(input logic [7:0] c, input logic [5:0] two_k,
                         input logic [5:0] one_k, input logic [1:0] e,
                         output logic rescan);
    mode = M_IDLE;
    if (c == CH_EQ) begin
      push_tok(two_k, E_NONE, 2, 0);
      step_pos(c);
      rescan = 1'b0;
    end else begin
      push_tok(one_k, e, 1, 0);
      rescan = 1'b1;
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    logic again;
    logic [63:0] d;
    logic [7:0] v;
    for (int pass = 0; pass < 3; pass++) begin
      again = 1'b0;
      case (mode)
        M_COMMENT: begin
          if (c == CH_NL) begin
            mode = M_IDLE;
            again = 1'b1;
          end else step_pos(c);
        end
        M_NEWLINES: begin
          if (c == CH_NL) begin
            tok_len = sat_inc(tok_len);
            step_pos(c);
          end else begin
            push_tok(K_NEWLINE, E_NONE, tok_len, 0);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_IDENT: begin
          if (letter(c) || digit(c)) begin
            narrow_keywords(c, tok_len);
            tok_len = sat_inc(tok_len);
            step_pos(c);
          end else begin
            close_word();
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_INT: begin
          if (digit(c)) begin
            d = 64'(c - CH_0);
            acc = (acc > (64'(INT_MAX63) - d) / 10) ? 64'(INT_MAX63) : acc * 10 + d;
            tok_len = sat_inc(tok_len);
            step_pos(c);
          end else if (c == CH_DOT) begin
            mode = M_INT_DOT;
            step_pos(c);
          end else begin
            push_tok(K_INT, E_NONE, tok_len, acc[62:0]);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (digit(c)) begin
            tok_len = sat_inc(sat_inc(tok_len));
            mode = M_FLOAT;
            step_pos(c);
          end else begin
            close_int_dot();
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_FLOAT: begin
          if (digit(c)) begin
            tok_len = sat_inc(tok_len);
            step_pos(c);
          end else begin
            push_tok(K_FLOAT, E_NONE, tok_len, 0);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            tok_len = sat_inc(tok_len);
            push_tok(K_STRING, E_NONE, tok_len, 0);
            mode = M_IDLE;
            step_pos(c);
          end else if (c == CH_NL || str_bytes >= STR_LIMIT) begin
            push_tok(K_ERROR, E_UNTERM, tok_len, 0);
            mode = M_IDLE;
            again = 1'b1;
          end else if (c == CH_BSL) begin
            esc_line = cur_line;
            esc_col = cur_col;
            tok_len = sat_inc(tok_len);
            mode = M_STRING_ESC;
            step_pos(c);
          end else begin
            push(K_SBYTE, E_NONE, cur_line, cur_col, 1, 0, c);
            str_bytes++;
            tok_len = sat_inc(tok_len);
            step_pos(c);
          end
        end
        M_STRING_ESC: begin
          v = (c == CH_LN) ? CH_NL : (c == CH_LT_T) ? CH_TAB : c;
          push(K_SBYTE, E_NONE, esc_line, esc_col, 2, 0, v);
          str_bytes++;
          tok_len = sat_inc(tok_len);
          mode = M_STRING;
          step_pos(c);
        end
        M_EQ:   pair_op(c, K_EQEQ, K_ASSIGN, E_NONE, again);
        M_BANG: pair_op(c, K_NEQ, K_ERROR, E_BANG, again);
        M_LT:   pair_op(c, K_LE, K_LT, E_NONE, again);
        M_GT:   pair_op(c, K_GE, K_GT, E_NONE, again);
        default: begin
          mode = M_IDLE;
          scan_idle(c);
        end
      endcase
      if (!again) return;
    end
  endtask

  task automatic end_of_source();
    case (mode)
      M_NEWLINES:   push_tok(K_NEWLINE, E_NONE, tok_len, 0);
      M_IDENT:      close_word();
      M_INT:        push_tok(K_INT, E_NONE, tok_len, acc[62:0]);
      M_INT_DOT:    close_int_dot();
      M_FLOAT:      push_tok(K_FLOAT, E_NONE, tok_len, 0);
      M_STRING, M_STRING_ESC: push_tok(K_ERROR, E_UNTERM, tok_len, 0);
      M_EQ:         push_tok(K_ASSIGN, E_NONE, 1, 0);
      M_BANG:       push_tok(K_ERROR, E_BANG, 1, 0);
      M_LT:         push_tok(K_LT, E_NONE, 1, 0);
      M_GT:         push_tok(K_GT, E_NONE, 1, 0);
      default: ;
    endcase
    push(K_EOF, E_NONE, cur_line, cur_col, 0, 0, 8'h00);
    clear_state();
  endtask

  task automatic predict(input stl_in_t it);
    int n0;
    n0 = token_q.size();
    if (it.is_end) end_of_source();
    else scan_byte(it.source_byte);
    if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
  endtask

  task automatic compare(input stl_out_t got);
    stl_out_t want;
    if (token_q.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("ERROR: unexpected token %p", got);
      return;
    end
    want = token_q.pop_front();
    if (got !== want) begin
      err_count++;
      if (err_count <= 10)
        $display("ERROR: token mismatch\n  expected %p\n  actual   %p", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_valid && !in_stall) predict(in_item);
      if (out_valid && !out_stall) compare(out_data);
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench top for the script token lexer: drives source bytes in random
// bursts, stalls the token output, and gives the verdict.
// Depends on stl_pkg, stl_checker and the lexer RTL.
`default_nettype none

module tb_top;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT = 50000;
  localparam int RANDOM_ITEMS = 320;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  stl_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  stl_out_t out_data;
  int       errors, pending;

  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_mode = 0, stall_left = 0;

  string kw_names[13] = '{"print", "if", "elif", "else", "while", "def", "return",
                          "and", "or", "not", "True", "False", "None"};
  string op_text[22] = '{"(", ")", "{", "}", "[", "]", ",", ":", ".", "+", "-", "*",
                         "/", "%", "=", "==", "!=", "<", ">", "<=", ">=", "!"};

  always #5 clk = ~clk;

  script_token_lexer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  stl_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // Receiver stall: picks a new character per random-length stretch -- free
  // running, light random, heavy random, or solid stalls alternating with free.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycles / 8) % 2 == 1);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One item per call. Called at a rising edge; valid stays high across
  // back-to-back items, drops only for a gap between bursts.
  task automatic send_item(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_item <= '{source_byte: b, is_end: e};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return CH_UND;
    return 8'("0" + r - 53);
  endfunction

  // string body: plain bytes of any value but quote, newline and backslash,
  // escapes of all sorts, now and then an unescaped newline or an end inside it
  task automatic send_string();
    int n;
    logic [7:0] b;
    send_item(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(CH_BSL, 1'b0);
        case ($urandom_range(0, 4))
          0: send_item(CH_LN, 1'b0);
          1: send_item(CH_LT_T, 1'b0);
          2: send_item(CH_NL, 1'b0);
          3: send_item(CH_QUOTE, 1'b0);
          default: send_item(8'($urandom), 1'b0);
        endcase
      end else begin
        do b = 8'($urandom); while (b == CH_QUOTE || b == CH_NL || b == CH_BSL);
        send_item(b, 1'b0);
      end
    end
    case ($urandom_range(0, 9))
      0: send_item(CH_NL, 1'b0);
      1: send_end();
      2: begin
        send_item(CH_BSL, 1'b0);
        send_end();
      end
      default: send_item(CH_QUOTE, 1'b0);
    endcase
  endtask

  task automatic send_fragment();
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1: send_text(kw_names[$urandom_range(0, 12)]);
      2, 3: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) send_item(word_char(i == 0), 1'b0);
      end
      4: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_item(CH_DOT, 1'b0);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
      end
      5, 6: send_text(op_text[$urandom_range(0, 21)]);
      7, 8: send_string();
      9: begin
        send_item(CH_HASH, 1'b0);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          do b = 8'($urandom); while (b == CH_NL);
          send_item(b, 1'b0);
        end
        send_item(CH_NL, 1'b0);
      end
      10, 11: send_item(($urandom_range(0, 2) == 0) ? CH_TAB :
                        ($urandom_range(0, 3) == 0) ? CH_CR : CH_SP, 1'b0);
      12: begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(CH_NL, 1'b0);
      end
      13: send_item(8'($urandom), 1'b0);
      14: if ($urandom_range(0, 3) == 0) send_end();
      default: send_item(CH_SP, 1'b0);
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: int then dot then digit, int-dot with no digit, lone bang,
    // escapes (including an escaped newline), newline inside a string,
    // NUL and top byte values, comment, == and end right after "<".
    send_text("12.5 7.!x\"\\n\\\n\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("#c\n==<");
    send_end();

    // random token soup
    while (sent < 25 + RANDOM_ITEMS) send_fragment();
    send_end();

    send_text("if \"ab\" 3.14");
    send_end();

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
